// File: rtl/core/ukst_pkg.sv
// Package for the unordered key set table.
// Holds the request and response item types and the operation and status codes.
// No dependencies.
package ukst_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int USED_W   = 8;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [USED_W-1:0]   entries_used;
    } t_rsp;

    // Per-cell update controls for one finishing request.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// File: rtl/core/ukst_req_if.sv
// Request channel interface for the unordered key set table.
// Depends on ukst_pkg.
interface ukst_req_if;
    logic            valid;
    logic            ready;
    ukst_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/ukst_rsp_if.sv
// Response channel interface for the unordered key set table.
// Depends on ukst_pkg.
interface ukst_rsp_if;
    logic            valid;
    logic            ready;
    ukst_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/unordered_key_set_table_top.sv
// Top level of the unordered key set table: a row of key cells with a small sequencer.
// Depends on ukst_pkg, ukst_req_if, ukst_rsp_if, ukst_cell and ukst_prio.
//
//  Channel   Direction  Payload                         Handshake
//  i_req     in         op, key                         valid/ready
//  o_rsp     out        status, position, entries_used  valid/ready
//
// Each request passes through the sequencer states S_CMP, in which every cell
// compares its key with the request key, and S_DONE, in which the lowest match
// is picked and the table is updated. The next request is accepted in S_DONE as
// the current one finishes, never earlier, whatever the fill.
// Reset (synchronous, active low) empties the table; cell contents are not cleared.
// A stalled response holds the sequencer in S_DONE until it is taken.
module unordered_key_set_table_top #(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_WIDTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ukst_req_if.sink    i_req,
    ukst_rsp_if.source  o_rsp
);
    import ukst_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [OP_W-1:0]      r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] req_key;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_rsp_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;

    logic [TABLE_DEPTH-1:0] match;
    logic [KEY_WIDTH-1:0]   cell_key [TABLE_DEPTH];
    t_cell_ctl              cell_ctl [TABLE_DEPTH];
    logic                   found;
    logic [IDX_W-1:0]       hit;

    logic accept;
    logic finish;
    logic cmp_en;
    logic ins_ok;
    logic del_ok;
    logic full;
    logic empty;

    // The key is compared on its low KEY_WIDTH bits, or zero-extended if KEY_WIDTH is wider.
    generate
        if (KEY_WIDTH <= KEY_W) begin : g_key_narrow
            assign req_key = i_req.data.key[KEY_WIDTH-1:0];
        end else begin : g_key_wide
            assign req_key = {{(KEY_WIDTH - KEY_W){1'b0}}, i_req.data.key};
        end
    endgenerate

    assign cmp_en = (r_state == S_CMP);
    // A request finishes once its response has somewhere to go.
    assign finish = (r_state == S_DONE) && (!r_rsp_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE) || finish;
    assign accept = i_req.valid && i_req.ready;

    assign full  = (r_count == CNT_W'(TABLE_DEPTH));
    assign empty = (r_count == '0);

    // The row of cells; each hands its key down to its lower neighbor on delete.
    generate
        for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [KEY_WIDTH-1:0] next_key;
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign next_key = cell_key[g];
            end else begin : g_mid
                assign next_key = cell_key[g + 1];
            end

            assign cell_ctl[g].load  = finish && ins_ok && (r_count == CNT_W'(g));
            assign cell_ctl[g].shift = finish && del_ok && (IDX_W'(g) >= hit);

            ukst_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_key      (r_key),
                .i_cmp_en   (cmp_en),
                .i_in_use   (CNT_W'(g) < r_count),
                .i_ctl      (cell_ctl[g]),
                .i_next_key (next_key),
                .o_key      (cell_key[g]),
                .o_match    (match[g])
            );
        end
    endgenerate

    ukst_prio #(
        .WIDTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_prio (
        .i_match (match),
        .o_found (found),
        .o_idx   (hit)
    );

    // Decision for the request in S_DONE.
    always_comb begin
        logic [IDX_W+POS_W-1:0]  hit_ext;
        logic [CNT_W+POS_W-1:0]  cnt_pos;
        logic [CNT_W+USED_W-1:0] cnt_used;
        hit_ext  = {{POS_W{1'b0}}, hit};
        cnt_pos  = {{POS_W{1'b0}}, r_count};
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        n_count  = r_count;
        n_rsp.status   = STAT_OK;
        n_rsp.position = '0;
        priority case (1'b1)
            (r_op == OP_INSERT): begin
                if (full) begin
                    n_rsp.status = STAT_LIMIT;
                end else if (found) begin
                    n_rsp.status   = STAT_MISS;
                    n_rsp.position = hit_ext[POS_W-1:0];
                end else begin
                    ins_ok         = 1'b1;
                    n_rsp.position = cnt_pos[POS_W-1:0];
                    n_count        = r_count + CNT_W'(1);
                end
            end
            (r_op == OP_DELETE): begin
                if (empty) begin
                    n_rsp.status = STAT_LIMIT;
                end else if (!found) begin
                    n_rsp.status = STAT_MISS;
                end else begin
                    del_ok         = 1'b1;
                    n_rsp.position = hit_ext[POS_W-1:0];
                    n_count        = r_count - CNT_W'(1);
                end
            end
            default: begin
                // Search, and the unused op code, which behaves as a search.
                if (found) begin
                    n_rsp.position = hit_ext[POS_W-1:0];
                end else begin
                    n_rsp.status = STAT_MISS;
                end
            end
        endcase
        cnt_used = {{USED_W{1'b0}}, n_count};
        n_rsp.entries_used = cnt_used[USED_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (finish) begin
                    n_state = accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.data.op;
            r_key <= req_key;
        end
        if (finish) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;
endmodule

// File: rtl/core/ukst_cell.sv
// One slot of the key table: a stored key and a registered match flag.
// Depends on ukst_pkg.
module ukst_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic                 i_cmp_en,
    input  logic                 i_in_use,
    input  ukst_pkg::t_cell_ctl  i_ctl,
    input  logic [KEY_WIDTH-1:0] i_next_key,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic                 o_match
);
    import ukst_pkg::*;

    logic [KEY_WIDTH-1:0] r_key;
    logic                 r_match;

    // Payload: a new key lands on insert, the upper neighbor's key on delete.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= i_key;
        end else if (i_ctl.shift) begin
            r_key <= i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp_en) begin
            r_match <= i_in_use && (r_key == i_key);
        end
    end

    assign o_key   = r_key;
    assign o_match = r_match;
endmodule

// File: rtl/core/ukst_prio.sv
// Lowest-set-bit finder over the row of cell match flags.
// Depends on nothing.
module ukst_prio #(
    parameter int WIDTH = 128,
    parameter int IDX_W = 7
) (
    input  logic [WIDTH-1:0] i_match,
    output logic             o_found,
    output logic [IDX_W-1:0] o_idx
);
    always_comb begin
        o_idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

    assign o_found = |i_match;
endmodule

// File: rtl/core/ukst_chk.sv
// Port-level checks for the unordered key set table, bound to its top level.
// Depends on ukst_pkg and unordered_key_set_table_top.
module ukst_chk #(
    parameter int TABLE_DEPTH = 128
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input ukst_pkg::t_rsp i_rsp_data
);
    import ukst_pkg::*;

    localparam logic [USED_W-1:0] DEPTH_USED = USED_W'(TABLE_DEPTH);

    // No response may appear in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // A stalled response keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)))
        else $error("stalled response changed");

    // A full or empty report only happens at the table's limits.
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_data.status == STAT_LIMIT)) |->
        ((i_rsp_data.entries_used == '0) || (i_rsp_data.entries_used == DEPTH_USED)))
        else $error("limit status away from the table limits");

    // Status never carries the unused code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_rsp_data.status == STAT_OK) ||
                         (i_rsp_data.status == STAT_LIMIT) ||
                         (i_rsp_data.status == STAT_MISS)))
        else $error("unused status code");
endmodule

bind unordered_key_set_table_top ukst_chk #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ukst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// File: dv/unordered_key_set_table_top_tb.sv
// Testbench for unordered_key_set_table_top: directed, fill-to-capacity, random and
// output back-pressure tests, each checked against a behavioral model of the key table.
// Depends on ukst_pkg, ukst_req_if, ukst_rsp_if and the RTL of the block.
module unordered_key_set_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ukst_pkg::*;

    localparam int TABLE_DEPTH  = 128;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PERCENT = 14;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int POOL_SIZE    = 200;
    localparam int PHASE_ITEMS  = 260;
    localparam int MAX_PRINTS   = 30;

    // The fourth op code has no name in the package; the block treats it as a search.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    ukst_req_if req_if ();
    ukst_rsp_if rsp_if ();

    unordered_key_set_table_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Model state: the packed key table as a queue (its size is the entry count),
    // and the responses that accepted requests still owe, oldest first.
    logic [KEY_W-1:0] table_keys[$];
    t_rsp             pending_rsps[$];

    // Keys drawn from a fixed pool repeat often enough to hit duplicates and matches.
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    bit send_idle_en;
    bit recv_stall_en;
    bit hold_request;
    bit recv_hold;

    int error_count;
    int items_accepted;
    int rsps_checked;
    int peak_fill;
    int quiet_cycles;
    int op_seen[4];
    int status_seen[4];

    // Applies one request to the model table and returns the response it must produce.
    function automatic t_rsp apply_request(t_req req);
        t_rsp rsp;
        int   hit;
        rsp.status   = STAT_OK;
        rsp.position = '0;
        hit          = -1;
        // Keys are distinct, but the lowest matching slot is what counts.
        for (int i = 0; i < table_keys.size(); i++) begin
            if (table_keys[i] == req.key) begin
                hit = i;
                break;
            end
        end
        case (req.op)
            OP_INSERT: begin
                // A full table refuses the insert before any duplicate check.
                if (table_keys.size() >= TABLE_DEPTH) begin
                    rsp.status = STAT_LIMIT;
                end else if (hit >= 0) begin
                    rsp.status   = STAT_MISS;
                    rsp.position = POS_W'(hit);
                end else begin
                    rsp.position = POS_W'(table_keys.size());
                    table_keys.push_back(req.key);
                end
            end
            OP_DELETE: begin
                if (table_keys.size() == 0) begin
                    rsp.status = STAT_LIMIT;
                end else if (hit < 0) begin
                    rsp.status = STAT_MISS;
                end else begin
                    // Removing from the queue closes the gap, as the table shifts down.
                    rsp.position = POS_W'(hit);
                    table_keys.delete(hit);
                end
            end
            default: begin
                // Search, and the unused code, which behaves as a search.
                if (hit >= 0) begin
                    rsp.position = POS_W'(hit);
                end else begin
                    rsp.status = STAT_MISS;
                end
            end
        endcase
        rsp.entries_used = USED_W'(table_keys.size());
        return rsp;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    // Offers one item and returns at the rising edge that accepts it. The valid
    // line stays high afterwards so that the next call can follow back to back.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        @(negedge i_clk);
        while (send_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            req_if.valid    = 1'b0;
            req_if.data.op  = OP_W'($urandom);
            req_if.data.key = $urandom;
            @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.data.op  = op;
        req_if.data.key = key;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Lowers valid and waits until every outstanding response has been checked.
    task automatic drain_responses();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) begin
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (roll < 80 && table_keys.size() > 0) begin
            return table_keys[$urandom_range(table_keys.size() - 1)];
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int insert_pct, input int delete_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < insert_pct) begin
            return OP_INSERT;
        end else if (roll < insert_pct + delete_pct) begin
            return OP_DELETE;
        end else if (roll < 97) begin
            return OP_SEARCH;
        end
        return OP_UNUSED;
    endfunction

    // Every operation on an empty table, the key extremes, duplicates, absent keys,
    // the unused op code, and deletes at the front, middle and back of the table.
    task automatic test_directed_cases();
        send_request(OP_SEARCH, 32'h0000_0005);     // search of an empty table
        send_request(OP_DELETE, 32'h0000_0005);     // delete from an empty table
        send_request(OP_UNUSED, 32'h0000_0005);
        send_request(OP_INSERT, 32'h8000_0000);     // most negative key
        send_request(OP_INSERT, 32'h7FFF_FFFF);     // most positive key
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0005);
        send_request(OP_INSERT, 32'h0000_0000);     // duplicate reports the existing slot
        send_request(OP_SEARCH, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h8000_0005);     // differs from a held key in the sign bit
        send_request(OP_UNUSED, 32'h7FFF_FFFF);
        send_request(OP_DELETE, 32'h0000_0006);     // delete of an absent key
        send_request(OP_DELETE, 32'h7FFF_FFFF);     // middle delete shifts later keys down
        send_request(OP_SEARCH, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h8000_0000);     // front
        send_request(OP_DELETE, 32'h0000_0005);     // back
        send_request(OP_SEARCH, 32'h0000_0005);
        send_request(OP_DELETE, 32'h0000_0000);
        send_request(OP_DELETE, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h0000_0000);     // table empty again
        drain_responses();
    endtask

    // Fills every slot with no idling on either side, then works the full table.
    task automatic test_fill_to_capacity();
        logic [KEY_W-1:0] fill_keys[$];
        logic [KEY_W-1:0] fresh_key;
        int               idx;
        send_idle_en  = 1'b0;
        recv_stall_en = 1'b0;
        // The slot number in the low bits keeps the fill keys distinct; bit 31 is
        // clear on all of them, so a key with it set is known to be absent.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            fill_keys.push_back({1'b0, 24'($urandom), 7'(i)});
            send_request(OP_INSERT, fill_keys[i]);
        end
        fresh_key = {1'b1, 31'($urandom)};
        send_request(OP_INSERT, fresh_key);         // full table
        send_request(OP_INSERT, fill_keys[5]);      // full wins over duplicate
        send_request(OP_SEARCH, fill_keys[TABLE_DEPTH - 1]);
        send_request(OP_DELETE, fill_keys[0]);      // shifts the whole table
        send_request(OP_INSERT, fresh_key);         // lands in the top slot
        send_request(OP_SEARCH, fresh_key);
        drain_responses();
        // Empty the table again in a random order.
        fill_keys = table_keys;
        while (fill_keys.size() > 0) begin
            idx = $urandom_range(fill_keys.size() - 1);
            send_request(OP_DELETE, fill_keys[idx]);
            fill_keys.delete(idx);
        end
        drain_responses();
        send_idle_en  = 1'b1;
        recv_stall_en = 1'b1;
    endtask

    // Phases lean toward inserts or deletes, the last one neither, so that the fill sweeps the whole range.
    task automatic test_random_traffic();
        int insert_pct;
        int delete_pct;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0, 2:    begin insert_pct = 60; delete_pct = 20; end
                1:       begin insert_pct = 20; delete_pct = 60; end
                default: begin insert_pct = 35; delete_pct = 35; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(pick_op(insert_pct, delete_pct), pick_key());
            end
        end
        drain_responses();
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the
    // block backs up and must stall its request side without losing anything.
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++) begin
            send_request(pick_op(40, 30), pick_key());
        end
        drain_responses();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Response side ready, redrawn each falling edge; the hold overrides it.
    always @(negedge i_clk) begin
        rsp_if.ready = !recv_hold && !(recv_stall_en && $urandom_range(99) < IDLE_PERCENT);
    end

    // Long receiver hold, timed in its own process.
    initial begin
        recv_hold = 1'b0;
        forever begin
            wait (hold_request);
            recv_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            recv_hold    = 1'b0;
            hold_request = 1'b0;
        end
    end

    // Prediction and checking. An accepted request is modeled before the response
    // of the same edge is popped, so the oldest expectation is always compared.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pending_rsps.push_back(apply_request(req_if.data));
                items_accepted++;
                op_seen[req_if.data.op]++;
                if (table_keys.size() > peak_fill) begin
                    peak_fill = table_keys.size();
                end
            end
            if (rsp_if.valid && rsp_if.ready) begin
                rsps_checked++;
                if (pending_rsps.size() == 0) begin
                    report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                              rsps_checked));
                end else begin
                    want = pending_rsps.pop_front();
                    status_seen[want.status]++;
                    if (rsp_if.data.status !== want.status) begin
                        report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                                  rsps_checked, rsp_if.data.status, want.status));
                    end
                    if (rsp_if.data.position !== want.position) begin
                        report_mismatch($sformatf("response %0d position %0d, expected %0d",
                                                  rsps_checked, rsp_if.data.position,
                                                  want.position));
                    end
                    if (rsp_if.data.entries_used !== want.entries_used) begin
                        report_mismatch($sformatf("response %0d entries_used %0d, expected %0d",
                                                  rsps_checked, rsp_if.data.entries_used,
                                                  want.entries_used));
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Timeout: no item moved for %0d cycles, %0d responses outstanding",
                             STALL_LIMIT, pending_rsps.size());
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        send_idle_en  = 1'b1;
        recv_stall_en = 1'b1;
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_fill_to_capacity();
        test_random_traffic();
        test_output_backpressure();

        // Let a stray extra response show up before the verdict.
        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d search, %0d insert, %0d delete, %0d unused op),",
                 items_accepted, op_seen[OP_SEARCH], op_seen[OP_INSERT], op_seen[OP_DELETE],
                 op_seen[OP_UNUSED]);
        $display("peak fill %0d of %0d; responses %0d ok, %0d limit, %0d miss; %0d mismatches.",
                 peak_fill, TABLE_DEPTH, status_seen[STAT_OK], status_seen[STAT_LIMIT],
                 status_seen[STAT_MISS], error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ukst_pkg.sv
rtl/core/ukst_req_if.sv
rtl/core/ukst_rsp_if.sv
rtl/core/ukst_cell.sv
rtl/core/ukst_prio.sv
rtl/core/unordered_key_set_table_top.sv
rtl/core/ukst_chk.sv
dv/unordered_key_set_table_top_tb.sv
